// ----- hdl/category_mask_boundary_marker_defines.svh -----
// ----------------------------------------------------------------------------
// Category mask boundary marker: assertion macros
// Concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef CATEGORY_MASK_BOUNDARY_MARKER_DEFINES_SVH
`define CATEGORY_MASK_BOUNDARY_MARKER_DEFINES_SVH

// same-cycle implication
`define CMBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmbm assertion failed");

// next-cycle implication
`define CMBM_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmbm assertion failed");

`endif

// ----- hdl/cmbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Category mask boundary marker package
// Shared widths, defaults, register indexes and class codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cmbm_pkg;

  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int COUNT_WIDTH_DEF = 25;
  localparam int NUM_CATEGORIES  = 64;

  localparam int VALUE_W     = 32;
  localparam int ROW_LEN_W   = 13;
  localparam int CAT_COUNT_W = 7;
  localparam int CAT_MASK_W  = 64;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int CLASS_W     = 2;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = ROW_LEN_W'(4096);

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CATEGORY_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CATEGORY_MASK  = 2'd2;

  localparam logic [CLASS_W-1:0] CLS_NONE     = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_EDGE     = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_INTERIOR = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/cmbm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module cmbm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/category_mask_boundary_marker.sv -----
// Output: a cell's result appears one row after the cell enters, in the cycle
//   after the item of the same column of the next row is accepted.
// Throughput: one item per cycle unless in_stall is high; line buffers are read ahead.
// Reset: synchronous; clears control state and counters, registers go to
//   row_length 4096, category_count 0, category_mask 0. Line buffers keep data.
// ----------------------------------------------------------------------------
// Category mask boundary marker
// Four-neighbor boundary classification over a raster stream with line
// buffers, saturating edge and selected cell counts.
// ----------------------------------------------------------------------------
`default_nettype none

module category_mask_boundary_marker #(
  parameter int MAX_COLUMNS = cmbm_pkg::MAX_COLUMNS_DEF,
  parameter int COUNT_WIDTH = cmbm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cmbm_pkg::VALUE_W-1:0] cell_value,
  input  logic                                pad_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cmbm_pkg::CLASS_W-1:0]        cell_class,
  output logic                                row_end,
  output logic                                map_end,
  output logic [COUNT_WIDTH-1:0]              edge_total,
  output logic [COUNT_WIDTH-1:0]              selected_total,
  input  logic                                cfg_we,
  input  logic [cmbm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cmbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cmbm_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int LEN_W = (ROW_LEN_W > COL_W + 1) ? ROW_LEN_W : COL_W + 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_COLUMNS);
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic [CAT_COUNT_W-1:0] CAT_LIM = CAT_COUNT_W'(NUM_CATEGORIES);

  localparam logic [1:0] ROWS_NONE = 2'd0;
  localparam logic [1:0] ROWS_ONE  = 2'd1;
  localparam logic [1:0] ROWS_TWO  = 2'd2;

  logic [ROW_LEN_W-1:0]   row_length;
  logic [CAT_COUNT_W-1:0] category_count;
  logic [CAT_MASK_W-1:0]  category_mask;

  logic [COL_W-1:0]       col;
  logic [COL_W-1:0]       col_next;
  logic [1:0]             rows;
  logic                   window;
  logic [COUNT_WIDTH-1:0] edge_cnt;
  logic [COUNT_WIDTH-1:0] sel_cnt;
  logic [COUNT_WIDTH-1:0] edge_cnt_next;
  logic [COUNT_WIDTH-1:0] sel_cnt_next;
  logic                   byp;
  logic                   byp_bit;

  logic [LEN_W-1:0]       row_ext;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       col_ext;
  logic [CAT_COUNT_W-1:0] cnt_lim;
  logic                   sel;
  logic                   lower;
  logic                   last;
  logic                   first;
  logic                   drop;
  logic                   accept;
  logic                   advance;
  logic                   produce;
  logic                   counted;
  logic [1:0]             cur_q;
  logic                   rt_q;
  logic [COL_W-1:0]       rt_addr;
  logic                   cen;
  logic                   up;
  logic                   left;
  logic                   right;
  logic [CLASS_W-1:0]     cls;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= ROW_LENGTH_RST;
      category_count <= '0;
      category_mask  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_LENGTH:     row_length     <= cfg_data[ROW_LEN_W-1:0];
        REG_CATEGORY_COUNT: category_count <= cfg_data[CAT_COUNT_W-1:0];
        REG_CATEGORY_MASK:  category_mask  <= cfg_data[CAT_MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_ext = LEN_W'(row_length);
    if (row_ext < MIN_LEN) begin
      len = MIN_LEN;
    end else if (row_ext > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = row_ext;
    end
  end

  assign cnt_lim = (category_count > CAT_LIM) ? CAT_LIM : category_count;
  assign sel     = !cell_value[VALUE_W-1]
                   && (cell_value[VALUE_W-2:0] < (VALUE_W-1)'(cnt_lim))
                   && category_mask[cell_value[5:0]];
  assign lower   = pad_row | sel;

  assign col_ext = LEN_W'(col);
  assign last    = col_ext >= len - LEN_W'(1);
  assign counted = (col_ext >= LEN_W'(1)) && (col_ext + LEN_W'(1) < len);
  assign first   = rows == ROWS_NONE;
  assign drop    = first && pad_row && (col == '0);

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign advance  = accept & ~drop;
  assign produce  = accept & ~first;

  always_comb begin
    if (rst) begin
      col_next = '0;
    end else if (advance) begin
      col_next = last ? '0 : col + COL_W'(1);
    end else begin
      col_next = col;
    end
  end

  assign rt_addr = (col_next == LAST_COL) ? '0 : col_next + COL_W'(1);

  // {upper, center} at the current column
  cmbm_ram #(.WIDTH(2), .DEPTH(MAX_COLUMNS)) u_cur_ram (
    .clk   (clk),
    .we    (advance),
    .waddr (col),
    .wdata ({cen, lower}),
    .raddr (col_next),
    .rdata (cur_q)
  );

  // copy of the center row, read one column ahead
  cmbm_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_rt_ram (
    .clk   (clk),
    .we    (advance),
    .waddr (col),
    .wdata (lower),
    .raddr (rt_addr),
    .rdata (rt_q)
  );

  assign cen   = cur_q[0];
  assign up    = (rows == ROWS_ONE) ? 1'b1 : cur_q[1];
  assign left  = (col == '0) ? 1'b1 : window;
  assign right = last ? 1'b1 : (byp ? byp_bit : rt_q);

  always_comb begin
    if (!cen) begin
      cls = CLS_NONE;
    end else if (up && left && right && lower) begin
      cls = CLS_INTERIOR;
    end else begin
      cls = CLS_EDGE;
    end
  end

  always_comb begin
    edge_cnt_next = edge_cnt;
    sel_cnt_next  = sel_cnt;
    if (counted) begin
      if (cls == CLS_EDGE) begin
        edge_cnt_next = (edge_cnt < COUNT_MAX) ? edge_cnt + COUNT_WIDTH'(1) : COUNT_MAX;
      end
      if (cls != CLS_NONE) begin
        sel_cnt_next = (sel_cnt < COUNT_MAX) ? sel_cnt + COUNT_WIDTH'(1) : COUNT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp     <= advance && (rt_addr == col);
    byp_bit <= lower;
    if (rst) begin
      col      <= '0;
      rows     <= ROWS_NONE;
      window   <= 1'b0;
      edge_cnt <= '0;
      sel_cnt  <= '0;
    end else begin
      col <= col_next;
      if (advance) begin
        if (first) begin
          if (col == '0) begin
            edge_cnt <= '0;
            sel_cnt  <= '0;
          end
          if (last) begin
            rows <= ROWS_ONE;
          end
        end else begin
          edge_cnt <= edge_cnt_next;
          sel_cnt  <= sel_cnt_next;
          window   <= last ? 1'b0 : cen;
          if (last) begin
            rows <= pad_row ? ROWS_NONE : ROWS_TWO;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= produce;
    end
    if (produce) begin
      cell_class     <= cls;
      row_end        <= last;
      map_end        <= last & pad_row;
      edge_total     <= edge_cnt_next;
      selected_total <= sel_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cmbm_checker.sv -----
// ----------------------------------------------------------------------------
// Category mask boundary marker checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "category_mask_boundary_marker_defines.svh"

module cmbm_checker #(
  parameter int COUNT_WIDTH = cmbm_pkg::COUNT_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [cmbm_pkg::CLASS_W-1:0] cell_class,
  input logic                         row_end,
  input logic                         map_end,
  input logic [COUNT_WIDTH-1:0]       edge_total,
  input logic [COUNT_WIDTH-1:0]       selected_total
);

  import cmbm_pkg::*;

  `CMBM_ASSERT_NOW(a_map_end_row, clk, rst, out_valid && map_end, row_end)
  `CMBM_ASSERT_NOW(a_class_code, clk, rst, out_valid, cell_class <= CLS_INTERIOR)
  `CMBM_ASSERT_NOW(a_edge_le_sel, clk, rst, out_valid, edge_total <= selected_total)
  `CMBM_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && out_stall, $stable(selected_total))

endmodule

bind category_mask_boundary_marker cmbm_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_cmbm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .cell_class     (cell_class),
  .row_end        (row_end),
  .map_end        (map_end),
  .edge_total     (edge_total),
  .selected_total (selected_total)
);

`default_nettype wire

// ----- dv/category_mask_boundary_marker_tb.sv -----
// ----------------------------------------------------------------------------
// Category mask boundary marker testbench
// Streams raster maps through the block with random idle gaps on both sides.
// A scoreboard class predicts the class, row and map flags and the running
// counts of every result cell, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module category_mask_boundary_marker_tb;
  import cmbm_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = {1'b1, {(COUNT_WIDTH_DEF-1){1'b0}}};
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [CLASS_W-1:0]         cls;
    logic                       row_end;
    logic                       map_end;
    logic [COUNT_WIDTH_DEF-1:0] edge_total;
    logic [COUNT_WIDTH_DEF-1:0] sel_total;
  } cell_result_t;

  class boundary_scoreboard;
    logic [ROW_LEN_W-1:0]       row_length_q;
    logic [CAT_COUNT_W-1:0]     cat_count_q;
    logic [CAT_MASK_W-1:0]      cat_mask_q;
    bit                         upper_row[MAX_COLUMNS_DEF];
    bit                         center_row[MAX_COLUMNS_DEF];
    int unsigned                col_index;
    int unsigned                rows_held;
    bit                         left_bit;
    logic [COUNT_WIDTH_DEF-1:0] edge_count;
    logic [COUNT_WIDTH_DEF-1:0] sel_count;
    cell_result_t               expected_cells[$];
    int unsigned                errors;

    function new();
      row_length_q = ROW_LENGTH_RST;
      cat_count_q  = '0;
      cat_mask_q   = '0;
      col_index    = 0;
      rows_held    = 0;
      left_bit     = 1'b0;
      edge_count   = '0;
      sel_count    = '0;
      errors       = 0;
    endfunction

    function int unsigned eff_len();
      if (row_length_q < 2) return 2;
      if (row_length_q > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
      return row_length_q;
    endfunction

    function bit selects(logic signed [VALUE_W-1:0] v);
      int unsigned lim;
      lim = (cat_count_q > NUM_CATEGORIES) ? NUM_CATEGORIES : cat_count_q;
      if (v < 0) return 1'b0;
      if (int'(v) >= int'(lim)) return 1'b0;
      return cat_mask_q[v[5:0]];
    endfunction

    function logic [COUNT_WIDTH_DEF-1:0] bump(logic [COUNT_WIDTH_DEF-1:0] x);
      return (x < COUNT_MAX) ? x + 1'b1 : COUNT_MAX;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ROW_LENGTH: begin
          row_length_q = d[ROW_LEN_W-1:0];
        end
        REG_CATEGORY_COUNT: begin
          cat_count_q = d[CAT_COUNT_W-1:0];
        end
        REG_CATEGORY_MASK: begin
          cat_mask_q = d;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_cell(logic signed [VALUE_W-1:0] v, bit pad);
      int unsigned  n;
      int unsigned  c;
      bit           lower;
      bit           last;
      bit           cen;
      bit           up;
      bit           lft;
      bit           rgt;
      bit           done;
      cell_result_t r;
      n     = eff_len();
      c     = col_index;
      lower = pad ? 1'b1 : selects(v);
      last  = (c >= n - 1);
      if (rows_held == 0) begin
        if (pad && c == 0) return;
        if (c == 0) begin
          edge_count = '0;
          sel_count  = '0;
        end
        center_row[c] = lower;
        if (last) begin
          col_index = 0;
          rows_held = 1;
        end else begin
          col_index = c + 1;
        end
        return;
      end
      cen = center_row[c];
      up  = (rows_held == 1) ? 1'b1 : upper_row[c];
      lft = (c == 0) ? 1'b1 : left_bit;
      rgt = last ? 1'b1 : center_row[c + 1];
      if (!cen) r.cls = CLS_NONE;
      else if (up && lft && rgt && lower) r.cls = CLS_INTERIOR;
      else r.cls = CLS_EDGE;
      // outer columns are left out of the counts
      if (c >= 1 && c + 1 < n) begin
        if (r.cls == CLS_EDGE) edge_count = bump(edge_count);
        if (r.cls != CLS_NONE) sel_count = bump(sel_count);
      end
      upper_row[c]  = cen;
      center_row[c] = lower;
      left_bit      = cen;
      done = last && pad;
      if (last) begin
        col_index = 0;
        left_bit  = 1'b0;
        rows_held = done ? 0 : 2;
      end else begin
        col_index = c + 1;
      end
      r.row_end    = last;
      r.map_end    = done;
      r.edge_total = edge_count;
      r.sel_total  = sel_count;
      expected_cells.push_back(r);
    endfunction

    function void check_cell(logic [CLASS_W-1:0] cls, logic re, logic me,
                             logic [COUNT_WIDTH_DEF-1:0] et, logic [COUNT_WIDTH_DEF-1:0] st);
      cell_result_t e;
      if (expected_cells.size() == 0) begin
        $error("result with no item pending: cell_class %0d", cls);
        errors++;
        return;
      end
      e = expected_cells.pop_front();
      if (cls !== e.cls) begin
        $error("cell_class: expected %0d, got %0d", e.cls, cls);
        errors++;
      end
      if (re !== e.row_end) begin
        $error("row_end: expected %0d, got %0d", e.row_end, re);
        errors++;
      end
      if (me !== e.map_end) begin
        $error("map_end: expected %0d, got %0d", e.map_end, me);
        errors++;
      end
      if (et !== e.edge_total) begin
        $error("edge_total: expected %0d, got %0d", e.edge_total, et);
        errors++;
      end
      if (st !== e.sel_total) begin
        $error("selected_total: expected %0d, got %0d", e.sel_total, st);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [VALUE_W-1:0]  cell_value = '0;
  logic                       pad_row = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CLASS_W-1:0]         cell_class;
  logic                       row_end;
  logic                       map_end;
  logic [COUNT_WIDTH_DEF-1:0] edge_total;
  logic [COUNT_WIDTH_DEF-1:0] selected_total;
  logic                       cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]      cfg_addr = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  boundary_scoreboard sb;
  bit                 in_quiet = 1'b0;
  bit                 out_quiet = 1'b0;
  bit                 hold_off = 1'b0;
  bit                 flushing = 1'b0;
  int unsigned        rows_done = 0;
  int unsigned        map_rows = 1;
  int unsigned        max_map_rows = 1;
  int unsigned        noise_pct = 0;

  category_mask_boundary_marker u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cell_value     (cell_value),
    .pad_row        (pad_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cell_class     (cell_class),
    .row_end        (row_end),
    .map_end        (map_end),
    .edge_total     (edge_total),
    .selected_total (selected_total),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned gap_len(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    int unsigned lim;
    r   = $urandom_range(0, 99);
    lim = (sb.cat_count_q > NUM_CATEGORIES) ? NUM_CATEGORIES : sb.cat_count_q;
    if (r < 50 && lim > 0) return $urandom_range(0, lim - 1);
    if (r < 75) return $urandom_range(0, 63);
    if (r < 83) return $urandom_range(64, 200);
    if (r < 88) return -$urandom_range(1, 64);
    if (r < 90) return 32'sh8000_0000;
    if (r < 92) return 32'sh7FFF_FFFF;
    return $urandom;
  endfunction

  task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cell(logic signed [VALUE_W-1:0] v, bit pad);
    int unsigned g;
    g = gap_len(in_quiet);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cell_value <= v;
    pad_row    <= pad;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_cell(v, pad);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // maps of map_rows data rows closed by a pad row; noise flips the pad flag
  task automatic stream_items(int unsigned count);
    int unsigned sent;
    bit          pad;
    bit          ignored;
    sent = 0;
    while (sent < count) begin
      pad = flushing;
      if ($urandom_range(0, 99) < noise_pct) pad = ~pad;
      ignored = (sb.rows_held == 0 && sb.col_index == 0 && pad);
      send_cell(pick_value(), pad);
      if (!ignored) begin
        sent++;
        if (sb.col_index == 0) begin
          if (sb.rows_held == 0) begin
            flushing  = 1'b0;
            rows_done = 0;
            map_rows  = $urandom_range(1, max_map_rows);
          end else begin
            rows_done++;
            if (rows_done >= map_rows) flushing = 1'b1;
          end
        end
      end
    end
  endtask

  // row length may only grow while no map row is held
  task automatic pick_config();
    logic [CFG_DATA_W-1:0] d;
    int unsigned           r;
    int unsigned           rl;
    bit                    write_len;
    write_len = 1'b0;
    rl = 0;
    if ($urandom_range(0, 1)) begin
      if (sb.rows_held == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) rl = $urandom_range(0, 1);
        else if (r < 60) rl = $urandom_range(2, 8);
        else if (r < 85) rl = $urandom_range(9, 40);
        else rl = $urandom_range(41, 200);
        write_len = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        rl = $urandom_range(0, sb.eff_len());
        write_len = 1'b1;
      end
    end
    if (write_len) begin
      d = {$urandom, $urandom};
      if ($urandom_range(0, 1)) d = '0;
      d[ROW_LEN_W-1:0] = rl[ROW_LEN_W-1:0];
      set_reg(REG_ROW_LENGTH, d);
    end
    if ($urandom_range(0, 1)) begin
      d = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 40) d[CAT_COUNT_W-1:0] = CAT_COUNT_W'(NUM_CATEGORIES);
      else if (r < 55) d[CAT_COUNT_W-1:0] = CAT_COUNT_W'($urandom_range(65, 127));
      else if (r < 70) d[CAT_COUNT_W-1:0] = CAT_COUNT_W'($urandom_range(0, 63));
      else if (r < 80) d[CAT_COUNT_W-1:0] = '0;
      else d[CAT_COUNT_W-1:0] = CAT_COUNT_W'($urandom_range(48, 64));
      set_reg(REG_CATEGORY_COUNT, d);
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 99);
      if (r < 35) d = '1;
      else if (r < 65) d = {$urandom, $urandom} | {$urandom, $urandom};
      else if (r < 80) d = {$urandom, $urandom};
      else if (r < 90) d = '0;
      else d = {$urandom, $urandom} & {$urandom, $urandom};
      set_reg(REG_CATEGORY_MASK, d);
    end
    if ($urandom_range(0, 19) == 0) set_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_cell(cell_class, row_end, map_end, edge_total, selected_total);
    end
  end

  initial begin
    int unsigned g;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        g = gap_len(out_quiet);
        if (g == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned total;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every category selected
    set_reg(REG_CATEGORY_COUNT, NUM_CATEGORIES);
    set_reg(REG_CATEGORY_MASK, '1);

    // value extremes, dropped pad, pad inside the first row, interior cell
    set_reg(REG_ROW_LENGTH, 3);
    set_reg(REG_CATEGORY_COUNT, 127);
    set_reg(REG_CATEGORY_MASK, 64'hFFFF_FFFF_FFFF_FFDF);
    send_cell($urandom, 1'b1);
    send_cell(0, 1'b0); send_cell($urandom, 1'b1); send_cell(63, 1'b0);
    send_cell(1, 1'b0); send_cell(2, 1'b0); send_cell(3, 1'b0);
    send_cell(32'sh8000_0000, 1'b0); send_cell(32'sh7FFF_FFFF, 1'b0); send_cell(5, 1'b0);
    send_cell(64, 1'b0); send_cell(4, 1'b0); send_cell(-1, 1'b0);
    send_cell($urandom, 1'b1); send_cell($urandom, 1'b1); send_cell($urandom, 1'b1);
    wait_idle();

    // row length grown between maps, then shrunk mid-row below the minimum
    set_reg(REG_ROW_LENGTH, 4);
    send_cell(7, 1'b0); send_cell(8, 1'b0); send_cell(9, 1'b0); send_cell(10, 1'b0);
    send_cell(11, 1'b0); send_cell(12, 1'b0); send_cell(13, 1'b0);
    wait_idle();
    set_reg(REG_ROW_LENGTH, 0);
    send_cell(14, 1'b0);
    send_cell($urandom, 1'b1); send_cell($urandom, 1'b1);
    wait_idle();

    flushing     = 1'b0;
    rows_done    = 0;
    map_rows     = 1;
    max_map_rows = 6;
    noise_pct    = 8;
    total        = 0;
    // first phase: receiver holds off while the sender keeps going
    set_reg(REG_ROW_LENGTH, 5);
    in_quiet = 1'b1;
    hold_off = 1'b1;
    stream_items(300);
    total += 300;
    wait_idle();
    while (total < RANDOM_ITEMS) begin
      pick_config();
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      g_items: begin
        int unsigned n;
        n = $urandom_range(20, 150);
        stream_items(n);
        total += n;
      end
      wait_idle();
    end

    // close the open map
    noise_pct = 0;
    while (sb.rows_held != 0 || sb.col_index != 0) send_cell(pick_value(), 1'b1);
    wait_idle();

    // row length above the column maximum, then shrunk inside the first row
    set_reg(REG_ROW_LENGTH, 8191);
    send_cell(1, 1'b0); send_cell(2, 1'b0); send_cell(3, 1'b0);
    wait_idle();
    set_reg(REG_ROW_LENGTH, 3);
    send_cell(4, 1'b0); send_cell(5, 1'b0); send_cell(6, 1'b0); send_cell(7, 1'b0);
    send_cell($urandom, 1'b1); send_cell($urandom, 1'b1); send_cell($urandom, 1'b1);
    wait_idle();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
